// ===== design/trms_pkg.sv =====
package trms_pkg;

  localparam int unsigned TubeRadiusDef = 256;
  localparam int unsigned RingRadiusDef = 512;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned CX_W    = 32;
  localparam int unsigned ITER_W  = 5;
  localparam int unsigned D_W     = 17;
  localparam int unsigned T_W     = 18;
  localparam int unsigned PROD_W  = D_W + DATA_W;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned SHADE_W = 4;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned T_START     = 512;
  localparam int unsigned T_LIMIT     = 8 * 256;
  localparam int unsigned SHADE_SHIFT = 9;
  localparam int unsigned DIR_FRAC    = 14;
  localparam int unsigned POS_SHIFT   = 5;
  localparam int unsigned SHADE_MISS  = 12;
  localparam int unsigned SHADE_MAX   = 11;
  localparam int unsigned ITER_RESET  = 8;
  localparam int unsigned HIT_DIST    = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_FIRST_ITER,
    REG_SECOND_ITER
  } trms_reg_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } trms_axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD1,
    ST_ITER1,
    ST_LOAD2,
    ST_ITER2,
    ST_EVAL,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_EMIT
  } trms_state_e;

  typedef struct packed {
    logic       start;
    logic       load1;
    logic       load2;
    logic       iter;
    logic       eval;
    logic       adv;
    trms_axis_e axis;
    logic       emit;
  } trms_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic hit;
    logic miss;
  } trms_sts_t;

endpackage

// ===== design/trms_ctrl.sv =====
module trms_ctrl
  import trms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  trms_sts_t sts_i,
  output trms_cmd_t cmd_o
);

  trms_state_e state_q, state_d;
  logic        m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.axis = AXIS_X;
    s_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_LOAD1;
        end
      end
      ST_LOAD1: begin
        cmd_o.load1 = 1'b1;
        state_d     = ST_ITER1;
      end
      ST_ITER1: begin
        if (sts_i.iter_done) begin
          state_d = ST_LOAD2;
        end else begin
          cmd_o.iter = 1'b1;
        end
      end
      ST_LOAD2: begin
        cmd_o.load2 = 1'b1;
        state_d     = ST_ITER2;
      end
      ST_ITER2: begin
        if (sts_i.iter_done) begin
          state_d = ST_EVAL;
        end else begin
          cmd_o.iter = 1'b1;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.hit || sts_i.miss) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.adv  = 1'b1;
        cmd_o.axis = AXIS_X;
        state_d    = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.adv  = 1'b1;
        cmd_o.axis = AXIS_Y;
        state_d    = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd_o.adv  = 1'b1;
        cmd_o.axis = AXIS_Z;
        state_d    = ST_LOAD1;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== design/trms_dpath.sv =====
module trms_dpath
  import trms_pkg::*;
#(
  parameter int unsigned TUBE_RADIUS = TubeRadiusDef,
  parameter int unsigned RING_RADIUS = RingRadiusDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_W-1:0]  cfg_data_i,
  input  logic [3*DATA_W-1:0] dir_i,
  input  trms_cmd_t          cmd_i,
  output trms_sts_t          sts_o,
  output logic [SHADE_W-1:0] shade_o,
  output logic [STEP_W-1:0]  steps_o
);

  // configuration
  logic signed [DATA_W-1:0] start_x_q, start_y_q, start_z_q;
  logic signed [DATA_W-1:0] light_x_q, light_y_q, light_z_q;
  logic [ITER_W-1:0]        n1_q, n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_z_q <= '0;
      light_x_q <= '0;
      light_y_q <= '0;
      light_z_q <= '0;
      n1_q      <= ITER_W'(ITER_RESET);
      n2_q      <= ITER_W'(ITER_RESET);
    end else if (cfg_we_i) begin
      unique case (trms_reg_e'(cfg_idx_i))
        REG_START_X:     start_x_q <= cfg_data_i;
        REG_START_Y:     start_y_q <= cfg_data_i;
        REG_START_Z:     start_z_q <= cfg_data_i;
        REG_LIGHT_X:     light_x_q <= cfg_data_i;
        REG_LIGHT_Y:     light_y_q <= cfg_data_i;
        REG_LIGHT_Z:     light_z_q <= cfg_data_i;
        REG_FIRST_ITER:  n1_q      <= cfg_data_i[ITER_W-1:0];
        REG_SECOND_ITER: n2_q      <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // ray state
  logic signed [DATA_W-1:0] dir_q [3];
  logic signed [DATA_W-1:0] pos_q [3];
  logic signed [T_W-1:0]    t_q;
  logic signed [D_W-1:0]    d_q;
  logic [STEP_W-1:0]        steps_q;
  logic [SHADE_W-1:0]       shade_q;
  logic [SHADE_W-1:0]       shade_out_q;
  logic [STEP_W-1:0]        steps_out_q;

  // cordic unit
  logic signed [DATA_W-1:0] x_q, y_q, cy_q;
  logic signed [CX_W-1:0]   cx_q;
  logic [ITER_W-1:0]        k_q, n_q;

  logic signed [DATA_W-1:0] xs, ys, cys;
  logic signed [CX_W-1:0]   cxs, cys_ext;
  logic signed [DATA_W-1:0] x_sc, c_sc, d1;
  logic signed [CX_W-1:0]   cx_sc;
  logic signed [DATA_W-1:0] ld_a, ld_b, ld_ca, ld_cb;
  logic signed [CX_W-1:0]   ld_ca_ext;
  logic signed [D_W-1:0]    d_full;
  logic signed [T_W-1:0]    t_new;
  logic signed [DATA_W-1:0] lz_n;
  logic [SHADE_W-1:0]       shade_lit;
  logic signed [DATA_W-1:0] dir_sel;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]               ax;

  assign xs      = x_q >>> k_q;
  assign ys      = y_q >>> k_q;
  assign cxs     = cx_q >>> k_q;
  assign cys     = cy_q >>> k_q;
  assign cys_ext = {{(CX_W-DATA_W){cys[DATA_W-1]}}, cys};

  assign x_sc  = (x_q >>> 1) + (x_q >>> 3);
  assign cx_sc = (cx_q >>> 1) + (cx_q >>> 3);
  assign c_sc  = cx_sc[DATA_W-1:0];
  assign d1    = x_sc - DATA_W'(RING_RADIUS);

  // the second pass measures the tube; the first feeds it the ring-plane distance
  always_comb begin
    if (cmd_i.load1) begin
      ld_a  = pos_q[0];
      ld_b  = pos_q[1];
      ld_ca = light_x_q;
      ld_cb = light_y_q;
    end else begin
      ld_a  = pos_q[2];
      ld_b  = d1;
      ld_ca = light_z_q;
      ld_cb = c_sc;
    end
  end
  assign ld_ca_ext = {{(CX_W-DATA_W){ld_ca[DATA_W-1]}}, ld_ca};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load1 || cmd_i.load2) begin
      x_q  <= ld_a[DATA_W-1] ? -ld_a : ld_a;
      cx_q <= ld_a[DATA_W-1] ? -ld_ca_ext : ld_ca_ext;
      y_q  <= ld_b;
      cy_q <= ld_cb;
      k_q  <= '0;
      n_q  <= cmd_i.load1 ? n1_q : n2_q;
    end else if (cmd_i.iter) begin
      if (y_q[DATA_W-1]) begin
        x_q  <= x_q - ys;
        y_q  <= y_q + xs;
        cx_q <= cx_q - cys_ext;
        cy_q <= cy_q + cxs[DATA_W-1:0];
      end else begin
        x_q  <= x_q + ys;
        y_q  <= y_q - xs;
        cx_q <= cx_q + cys_ext;
        cy_q <= cy_q - cxs[DATA_W-1:0];
      end
      k_q <= k_q + 1'b1;
    end
  end

  // march decision
  assign d_full = {x_sc[DATA_W-1], x_sc} - D_W'(TUBE_RADIUS);
  assign t_new  = t_q + {{(T_W-D_W){d_full[D_W-1]}}, d_full};
  assign lz_n   = c_sc >>> SHADE_SHIFT;

  always_comb begin
    if (lz_n <= 0) begin
      shade_lit = '0;
    end else if (lz_n > DATA_W'(SHADE_MAX)) begin
      shade_lit = SHADE_W'(SHADE_MAX);
    end else begin
      shade_lit = lz_n[SHADE_W-1:0];
    end
  end

  assign sts_o.iter_done = (k_q == n_q);
  assign sts_o.miss      = t_new > $signed(T_W'(T_LIMIT));
  assign sts_o.hit       = d_full < $signed(D_W'(HIT_DIST));

  // position advance, one axis per cycle
  assign ax      = cmd_i.axis;
  assign dir_sel = dir_q[ax];
  assign prod    = d_q * dir_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= dir_i[i*DATA_W +: DATA_W];
      end
      pos_q[0] <= start_x_q + ($signed(dir_i[0 +: DATA_W]) >>> POS_SHIFT);
      pos_q[1] <= start_y_q + ($signed(dir_i[DATA_W +: DATA_W]) >>> POS_SHIFT);
      pos_q[2] <= start_z_q + ($signed(dir_i[2*DATA_W +: DATA_W]) >>> POS_SHIFT);
      t_q      <= T_W'(T_START);
      steps_q  <= '0;
    end else begin
      if (cmd_i.eval) begin
        t_q     <= t_new;
        d_q     <= d_full;
        shade_q <= sts_o.miss ? SHADE_W'(SHADE_MISS) : shade_lit;
      end
      if (cmd_i.adv) begin
        pos_q[ax] <= pos_q[ax] + prod[DIR_FRAC +: DATA_W];
        if (cmd_i.axis == AXIS_Z && steps_q != '1) begin
          steps_q <= steps_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      shade_out_q <= shade_q;
      steps_out_q <= steps_q;
    end
  end

  assign shade_o = shade_out_q;
  assign steps_o = steps_out_q;

endmodule

// ===== design/torus_ray_march_shader_top.sv =====
// Sphere-traces one pixel ray against a fixed-point torus centered at the origin and
// returns a shade index (0..11 on a hit, 12 on a miss) and the number of march steps.
// Registers: 0..2 ray origin x/y/z, 3..5 light vector x/y/z, 6 and 7 the CORDIC
// iteration counts n1 and n2 (reset 8). One shared CORDIC unit runs one iteration per
// cycle. Each march step loads and iterates the ring-plane pass, then the tube pass,
// then evaluates; a step that continues advances the x, y and z positions one axis at
// a time, and the final step hands the result to the output register. Rays are handled
// one at a time; the next ray is taken while the previous result waits in the output
// register.
module torus_ray_march_shader_top
  import trms_pkg::*;
#(
  parameter int unsigned TUBE_RADIUS = TubeRadiusDef,
  parameter int unsigned RING_RADIUS = RingRadiusDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [DATA_W-1:0]   cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [3*DATA_W-1:0] s_axis_tdata,   // dir_x, dir_y, dir_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata    // shade, march_steps, zero pad
);

  trms_cmd_t          cmd;
  trms_sts_t          sts;
  logic [SHADE_W-1:0] shade;
  logic [STEP_W-1:0]  steps;

  trms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  trms_dpath #(
    .TUBE_RADIUS (TUBE_RADIUS),
    .RING_RADIUS (RING_RADIUS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dir_i      (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .shade_o    (shade),
    .steps_o    (steps)
  );

  assign m_axis_tdata = {2'b00, steps, shade};

endmodule

// ===== tb/torus_ray_march_shader_top_tb.sv =====
module torus_ray_march_shader_top_tb;
  import trms_pkg::*;

  typedef enum logic {
    ROW_WRITE,
    ROW_RAY
  } row_kind_e;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [STEP_W-1:0]  steps;
  } pixel_t;

  typedef struct packed {
    row_kind_e           kind;
    trms_reg_e           idx;
    logic [DATA_W-1:0]   value;
    logic [3*DATA_W-1:0] dir;
    logic                typed;
    pixel_t              pixel;
  } stim_row_t;

  typedef struct {
    longint len;
    longint comp;
  } cordic_out_t;

  localparam longint TubeR   = TubeRadiusDef;
  localparam longint RingR   = RingRadiusDef;
  localparam longint TStart  = T_START;
  localparam longint TLimit  = T_LIMIT;
  localparam longint HitDist = HIT_DIST;
  localparam longint MaxLit  = SHADE_MAX;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned CALM_ITEMS  = 1400;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]    cfg_idx_i     = '0;
  logic [DATA_W-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [3*DATA_W-1:0] s_axis_tdata  = '0;   // dir_x, dir_y, dir_z
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;         // shade, march_steps, zero pad

  logic [DATA_W-1:0] shadow_regs [8];
  pixel_t            pending_pixels [$];
  stim_row_t         stim_rows [$];
  int                errors       = 0;
  int                results_seen = 0;
  bit                calm         = 1'b0;

  torus_ray_march_shader_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint wrap16(longint v);
    shortint s;
    s = shortint'(v);
    return s;
  endfunction

  function automatic longint wrap32(longint v);
    int s;
    s = int'(v);
    return s;
  endfunction

  // vectoring cordic, companion pair rotated alongside
  function automatic cordic_out_t cordic_len(longint a, longint b, longint comp_x,
                                             longint comp_y, int unsigned n);
    longint      x, y, cx, cy, ox, ocx;
    int unsigned k;
    cordic_out_t res;
    x  = wrap16(a);
    y  = wrap16(b);
    cx = comp_x;
    cy = wrap16(comp_y);
    if (x < 0) begin
      x  = wrap16(-x);
      cx = wrap32(-cx);
    end
    for (k = 0; k < n; k++) begin
      ox  = x;
      ocx = cx;
      if (y < 0) begin
        x  = wrap16(x - (y >>> k));
        y  = wrap16(y + (ox >>> k));
        cx = wrap32(cx - (cy >>> k));
        cy = wrap16(cy + (ocx >>> k));
      end else begin
        x  = wrap16(x + (y >>> k));
        y  = wrap16(y - (ox >>> k));
        cx = wrap32(cx + (cy >>> k));
        cy = wrap16(cy - (ocx >>> k));
      end
    end
    res.comp = wrap16((cx >>> 1) + (cx >>> 3));
    res.len  = (x >>> 1) + (x >>> 3);
    return res;
  endfunction

  function automatic pixel_t trace_ray(logic [3*DATA_W-1:0] dir);
    longint      vx, vy, vz, px, py, pz, t, d, lx, lz, lit;
    int unsigned n1, n2, steps;
    cordic_out_t ring, tube;
    bit          done;
    pixel_t      res;
    vx    = longint'($signed(dir[DATA_W-1:0]));
    vy    = longint'($signed(dir[2*DATA_W-1:DATA_W]));
    vz    = longint'($signed(dir[3*DATA_W-1:2*DATA_W]));
    n1    = 32'(shadow_regs[REG_FIRST_ITER][ITER_W-1:0]);
    n2    = 32'(shadow_regs[REG_SECOND_ITER][ITER_W-1:0]);
    px    = wrap16(longint'($signed(shadow_regs[REG_START_X])) + (vx >>> POS_SHIFT));
    py    = wrap16(longint'($signed(shadow_regs[REG_START_Y])) + (vy >>> POS_SHIFT));
    pz    = wrap16(longint'($signed(shadow_regs[REG_START_Z])) + (vz >>> POS_SHIFT));
    t     = TStart;
    steps = 0;
    done  = 1'b0;
    res   = '0;
    while (!done) begin
      ring = cordic_len(px, py, longint'($signed(shadow_regs[REG_LIGHT_X])),
                        longint'($signed(shadow_regs[REG_LIGHT_Y])), n1);
      lx   = ring.comp;
      tube = cordic_len(pz, ring.len - RingR,
                        longint'($signed(shadow_regs[REG_LIGHT_Z])), lx, n2);
      lz   = tube.comp;
      d    = tube.len - TubeR;
      t    = t + d;
      if (t > TLimit) begin
        res.shade = SHADE_W'(SHADE_MISS);
        done      = 1'b1;
      end else if (d < HitDist) begin
        lit       = lz >>> SHADE_SHIFT;
        res.shade = SHADE_W'((lit <= 0) ? 0 : (lit > MaxLit) ? MaxLit : lit);
        done      = 1'b1;
      end else begin
        px = wrap16(px + ((d * vx) >>> DIR_FRAC));
        py = wrap16(py + ((d * vy) >>> DIR_FRAC));
        pz = wrap16(pz + ((d * vz) >>> DIR_FRAC));
        if (steps < 1023) steps++;
      end
    end
    res.steps = STEP_W'(steps);
    return res;
  endfunction

  function automatic stim_row_t ray_row(logic [DATA_W-1:0] dx, logic [DATA_W-1:0] dy,
                                        logic [DATA_W-1:0] dz, logic typed = 1'b0,
                                        int shade = 0, int steps = 0);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_RAY;
    row.dir   = {dz, dy, dx};
    row.typed = typed;
    row.pixel = {SHADE_W'(shade), STEP_W'(steps)};
    return row;
  endfunction

  function automatic stim_row_t reg_row(trms_reg_e idx, logic [DATA_W-1:0] value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    return row;
  endfunction

  task automatic write_reg(trms_reg_e idx, logic [DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    shadow_regs[idx] = value;
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_ray(logic [3*DATA_W-1:0] dir, logic typed, pixel_t typed_pixel);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dir;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(typed ? typed_pixel : trace_ray(dir));
  endtask

  // output side: random stalls plus one long hold so the block backs up
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 30) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 8);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[SHADE_W-1:0] !== want.shade) begin
          $error("shade: expected %0d, got %0d", want.shade, m_axis_tdata[SHADE_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[SHADE_W+STEP_W-1:SHADE_W] !== want.steps) begin
          $error("march_steps: expected %0d, got %0d", want.steps,
                 m_axis_tdata[SHADE_W+STEP_W-1:SHADE_W]);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("** torus_ray_march_shader_top: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t           row;
    bit                  in_write;
    int                  r, c;
    int unsigned         sent, n_items, it, iter_sum;
    logic [DATA_W-1:0]   v;
    logic [3*DATA_W-1:0] dir;

    for (r = 0; r < 8; r++) shadow_regs[r] = '0;
    shadow_regs[REG_FIRST_ITER]  = DATA_W'(ITER_RESET);
    shadow_regs[REG_SECOND_ITER] = DATA_W'(ITER_RESET);

    // reset settings: a still ray at the origin misses after five steps
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000, 1'b1, SHADE_MISS, 5));
    stim_rows.push_back(ray_row(16'h7fff, 16'h7fff, 16'h7fff));
    stim_rows.push_back(ray_row(16'h8000, 16'h8000, 16'h8000));
    stim_rows.push_back(ray_row(16'h8000, 16'h7fff, 16'h0000));
    stim_rows.push_back(ray_row(16'h0000, 16'h8000, 16'h7fff));
    stim_rows.push_back(ray_row(16'h4000, 16'h0000, 16'h0000));
    // eye inside the tube, negative distance
    stim_rows.push_back(reg_row(REG_START_X, 16'h0200));
    stim_rows.push_back(reg_row(REG_LIGHT_X, 16'h8000));
    stim_rows.push_back(reg_row(REG_LIGHT_Y, 16'h7fff));
    stim_rows.push_back(reg_row(REG_LIGHT_Z, 16'h7fff));
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000));
    stim_rows.push_back(ray_row(16'h0000, 16'h4000, 16'h0000));
    stim_rows.push_back(ray_row(16'hc000, 16'h0000, 16'h1000));
    // iteration counts past 16, shifts fill with the sign
    stim_rows.push_back(reg_row(REG_FIRST_ITER, 16'h001f));
    stim_rows.push_back(reg_row(REG_SECOND_ITER, 16'hffff));
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000));
    stim_rows.push_back(ray_row(16'h7fff, 16'h8000, 16'h7fff));
    stim_rows.push_back(reg_row(REG_FIRST_ITER, 16'h0000));
    stim_rows.push_back(reg_row(REG_SECOND_ITER, 16'h0000));
    stim_rows.push_back(reg_row(REG_LIGHT_Z, 16'h8000));
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000));
    stim_rows.push_back(ray_row(16'h8000, 16'h8000, 16'h8000));
    // most negative cordic x, negation wraps
    stim_rows.push_back(reg_row(REG_START_X, 16'h8000));
    stim_rows.push_back(reg_row(REG_START_Y, 16'h8000));
    stim_rows.push_back(reg_row(REG_START_Z, 16'h8000));
    stim_rows.push_back(reg_row(REG_FIRST_ITER, 16'h0010));
    stim_rows.push_back(reg_row(REG_SECOND_ITER, 16'h0010));
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000));
    stim_rows.push_back(ray_row(16'h7fff, 16'h7fff, 16'h7fff));
    stim_rows.push_back(reg_row(REG_START_X, 16'h7fff));
    stim_rows.push_back(reg_row(REG_START_Y, 16'h7fff));
    stim_rows.push_back(reg_row(REG_START_Z, 16'h7fff));
    stim_rows.push_back(reg_row(REG_FIRST_ITER, 16'h0001));
    stim_rows.push_back(reg_row(REG_SECOND_ITER, 16'h0002));
    stim_rows.push_back(ray_row(16'h0000, 16'h0000, 16'h0000));
    stim_rows.push_back(ray_row(16'h8000, 16'h8000, 16'h8000));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_write = 1'b0;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!in_write) drain_pixels();
        write_reg(row.idx, row.value);
        in_write = 1'b1;
      end else begin
        if (in_write) cfg_we_i <= 1'b0;
        in_write = 1'b0;
        send_ray(row.dir, row.typed, row.pixel);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      drain_pixels();
      iter_sum = 0;
      for (r = 0; r < 8; r++) begin
        if (r < 3) begin
          if ($urandom_range(0, 3) == 0) v = DATA_W'($urandom);
          else v = DATA_W'($urandom_range(0, 2047) - 1024);
        end else if (r < 6) begin
          v = DATA_W'($urandom);
        end else begin
          case ($urandom_range(0, 9))
            0:       it = 0;
            1:       it = $urandom_range(17, 31);
            2:       it = 16;
            default: it = $urandom_range(1, 15);
          endcase
          iter_sum += it;
          v      = DATA_W'($urandom);
          v[4:0] = ITER_W'(it);
        end
        write_reg(trms_reg_e'(r), v);
      end
      cfg_we_i <= 1'b0;
      n_items = (iter_sum > 32) ? 25 : 100;
      repeat (n_items) begin
        if ($urandom_range(0, 4) < 3) begin
          dir = (3*DATA_W)'({$urandom, $urandom});
        end else begin
          for (c = 0; c < 3; c++) begin
            v = DATA_W'($urandom_range(0, 32767) - 16384);
            dir[c*DATA_W +: DATA_W] = v;
          end
        end
        send_ray(dir, 1'b0, '0);
        sent++;
        calm = (sent >= CALM_ITEMS);
      end
    end

    drain_pixels();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("** torus_ray_march_shader_top: PASSED **");
    end else begin
      $display("** torus_ray_march_shader_top: FAILED **");
    end
    $finish;
  end

endmodule
